>>> rtl/core/circle_collision_response_assert.svh
// Assertion macros for the circle collision response RTL.
`ifndef CIRCLE_COLLISION_RESPONSE_ASSERT_SVH
`define CIRCLE_COLLISION_RESPONSE_ASSERT_SVH
// Check that a condition at a clock edge implies another at the same edge.
`define CCR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that a condition at a clock edge implies another after the delay given by dly.
`define CCR_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(dly) (cons)) \
		else $error(msg);
`endif

>>> rtl/core/ccr_pkg.sv
// Shared constants and payload types of the circle collision response pipeline.
package ccr_pkg;

	// fraction bits of the internal unit normal
	localparam int FRAC_BITS = 16;
	// fraction bits of the mass weights
	localparam int W_BITS = 30;
	// fraction bits of a bounce factor and the value one
	localparam int BNC_FRAC = 16;
	localparam int BOUNCE_ONE = 1 << BNC_FRAC;

	localparam int VEL_W = 32;
	localparam int OFS_W = 32;
	localparam int MASS_W = 32;
	localparam int RAD_W = 31;
	localparam int BNC_W = BNC_FRAC + 1;
	localparam int E_W = BNC_FRAC + 1;
	localparam int DV_W = VEL_W + 1;
	localparam int MAG_W = OFS_W;
	localparam int D2_W = 2 * MAG_W;
	localparam int MSUM_W = MASS_W + 1;
	localparam int LEN_W = MAG_W;
	localparam int REM_W = LEN_W + 1;
	localparam int ROOT_STAGES = LEN_W;
	localparam int WQ_W = ROOT_STAGES;
	localparam int MBL_W = WQ_W - W_BITS;
	localparam int W_W = W_BITS + 1;
	localparam int NORM_BITS = FRAC_BITS + 1;
	localparam int NMAG_W = FRAC_BITS + 1;
	localparam int NS_W = NMAG_W + 1;
	localparam int PX_W = DV_W + NS_W;
	localparam int DOT_W = PX_W + 1;
	localparam int DVM_W = DOT_W - FRAC_BITS;
	localparam int T_W = DVM_W + W_W - W_BITS;
	localparam int Q_W = T_W + E_W - BNC_FRAC + 1;
	localparam int D_W = Q_W + NMAG_W - FRAC_BITS;
	localparam int SUM_W = D_W + 2;

	// register stages of the front end and of the response back end
	localparam int PREP_STAGES = 2;
	localparam int RESP_STAGES = 6;
	localparam int LATENCY = PREP_STAGES + ROOT_STAGES + NORM_BITS + RESP_STAGES;

	// one circle pair on its way down the pipeline
	typedef struct packed {
		logic                    ovl;
		logic [E_W-1:0]          e;
		logic signed [DV_W-1:0]  dvx;
		logic signed [DV_W-1:0]  dvy;
		logic signed [VEL_W-1:0] avx;
		logic signed [VEL_W-1:0] avy;
		logic signed [VEL_W-1:0] bvx;
		logic signed [VEL_W-1:0] bvy;
		logic                    ox_neg;
		logic                    oy_neg;
		logic [MAG_W-1:0]        ox_mag;
		logic [MAG_W-1:0]        oy_mag;
		logic                    msum_zero;
	} item_t;

endpackage

>>> rtl/core/circle_collision_response.sv
// Circle pair collision response with restitution, fully pipelined.
// Pipeline: 2 front-end stages, 32 square-root stages, 17 normal-divider stages
// and 6 response stages lie between the start beat and the done strobe.
// Throughput: one pair per cycle; busy stays low, the receiver cannot stall.
// Reset: arst_n clears every valid bit at once; no result is strobed until fed.
module circle_collision_response (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [ccr_pkg::OFS_W-1:0]     offset_x,
	input  logic signed [ccr_pkg::OFS_W-1:0]     offset_y,
	input  logic signed [ccr_pkg::VEL_W-1:0]     a_vel_x,
	input  logic signed [ccr_pkg::VEL_W-1:0]     a_vel_y,
	input  logic signed [ccr_pkg::VEL_W-1:0]     b_vel_x,
	input  logic signed [ccr_pkg::VEL_W-1:0]     b_vel_y,
	input  logic [ccr_pkg::MASS_W-1:0]           a_mass,
	input  logic [ccr_pkg::MASS_W-1:0]           b_mass,
	input  logic [ccr_pkg::RAD_W-1:0]            a_radius,
	input  logic [ccr_pkg::RAD_W-1:0]            b_radius,
	input  logic [ccr_pkg::BNC_W-1:0]            a_bounce,
	input  logic [ccr_pkg::BNC_W-1:0]            b_bounce,
	output logic                                 done,
	output logic                                 overlapping,
	output logic                                 responded,
	output logic signed [ccr_pkg::VEL_W-1:0]     new_a_vel_x,
	output logic signed [ccr_pkg::VEL_W-1:0]     new_a_vel_y,
	output logic signed [ccr_pkg::VEL_W-1:0]     new_b_vel_x,
	output logic signed [ccr_pkg::VEL_W-1:0]     new_b_vel_y
);

	logic                           prep_vld;
	ccr_pkg::item_t                 prep_item;
	logic [ccr_pkg::D2_W-1:0]       prep_d2;
	logic [ccr_pkg::MASS_W-1:0]     prep_mb;
	logic [ccr_pkg::MSUM_W-1:0]     prep_msum;

	logic                           root_vld;
	ccr_pkg::item_t                 root_item;
	logic [ccr_pkg::LEN_W-1:0]      root_len;
	logic [ccr_pkg::WQ_W-1:0]       root_wq;
	logic                           root_wr_nz;

	logic                           norm_vld;
	ccr_pkg::item_t                 norm_item;
	logic [ccr_pkg::NMAG_W-1:0]     norm_nx, norm_ny;
	logic [ccr_pkg::W_W-1:0]        norm_wa, norm_wb;

	// the pipeline takes a beat every cycle
	assign busy = 1'b0;

	ccr_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (start && !busy),
		.offset_x (offset_x),
		.offset_y (offset_y),
		.a_vel_x  (a_vel_x),
		.a_vel_y  (a_vel_y),
		.b_vel_x  (b_vel_x),
		.b_vel_y  (b_vel_y),
		.a_mass   (a_mass),
		.b_mass   (b_mass),
		.a_radius (a_radius),
		.b_radius (b_radius),
		.a_bounce (a_bounce),
		.b_bounce (b_bounce),
		.vld_s2   (prep_vld),
		.item_s2  (prep_item),
		.d2_s2    (prep_d2),
		.mb_s2    (prep_mb),
		.msum_s2  (prep_msum)
	);

	ccr_root u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_in    (prep_vld),
		.item_in   (prep_item),
		.d2_in     (prep_d2),
		.mb_in     (prep_mb),
		.msum_in   (prep_msum),
		.vld_out   (root_vld),
		.item_out  (root_item),
		.len_out   (root_len),
		.wq_out    (root_wq),
		.wr_nz_out (root_wr_nz)
	);

	ccr_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (root_vld),
		.item_in  (root_item),
		.len_in   (root_len),
		.wq_in    (root_wq),
		.wr_nz_in (root_wr_nz),
		.vld_out  (norm_vld),
		.item_out (norm_item),
		.nx_mag   (norm_nx),
		.ny_mag   (norm_ny),
		.wa_out   (norm_wa),
		.wb_out   (norm_wb)
	);

	ccr_resp u_resp (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (norm_vld),
		.item_in (norm_item),
		.nx_mag  (norm_nx),
		.ny_mag  (norm_ny),
		.wa_in   (norm_wa),
		.wb_in   (norm_wb),
		.vld_s6  (done),
		.ovl_s6  (overlapping),
		.resp_s6 (responded),
		.avx_s6  (new_a_vel_x),
		.avy_s6  (new_a_vel_y),
		.bvx_s6  (new_b_vel_x),
		.bvy_s6  (new_b_vel_y)
	);

`include "circle_collision_response_assert.svh"

	// every accepted pair comes out after the full pipeline depth
	`CCR_ASSERT_DLY(a_latency, start && !busy, ccr_pkg::LATENCY, done, "accepted beat lost")
	// no result without a beat taken the pipeline depth earlier
	`CCR_ASSERT_IMP(a_origin, done, $past(start && !busy, ccr_pkg::LATENCY), "spurious result")
	// a response needs an overlap
	`CCR_ASSERT_IMP(a_resp_ovl, done && responded, overlapping, "response without overlap")

endmodule

>>> rtl/core/ccr_prep.sv
// Front end: squares, overlap test, combined bounce factor and mass sum.
module ccr_prep (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 vld_in,
	input  logic signed [ccr_pkg::OFS_W-1:0]     offset_x,
	input  logic signed [ccr_pkg::OFS_W-1:0]     offset_y,
	input  logic signed [ccr_pkg::VEL_W-1:0]     a_vel_x,
	input  logic signed [ccr_pkg::VEL_W-1:0]     a_vel_y,
	input  logic signed [ccr_pkg::VEL_W-1:0]     b_vel_x,
	input  logic signed [ccr_pkg::VEL_W-1:0]     b_vel_y,
	input  logic [ccr_pkg::MASS_W-1:0]           a_mass,
	input  logic [ccr_pkg::MASS_W-1:0]           b_mass,
	input  logic [ccr_pkg::RAD_W-1:0]            a_radius,
	input  logic [ccr_pkg::RAD_W-1:0]            b_radius,
	input  logic [ccr_pkg::BNC_W-1:0]            a_bounce,
	input  logic [ccr_pkg::BNC_W-1:0]            b_bounce,
	output logic                                 vld_s2,
	output ccr_pkg::item_t                       item_s2,
	output logic [ccr_pkg::D2_W-1:0]             d2_s2,
	output logic [ccr_pkg::MASS_W-1:0]           mb_s2,
	output logic [ccr_pkg::MSUM_W-1:0]           msum_s2
);

	logic [ccr_pkg::MAG_W-1:0]     ox_u, oy_u, ox_mag, oy_mag;
	logic [ccr_pkg::MAG_W-1:0]     rs;
	logic [ccr_pkg::BNC_W-1:0]     ea_sat, eb_sat;
	logic [ccr_pkg::MSUM_W-1:0]    msum;

	logic                          vld_s1;
	ccr_pkg::item_t                item_s1;
	logic [ccr_pkg::D2_W-1:0]      ox2_s1, oy2_s1, rs2_s1;
	logic [2*ccr_pkg::BNC_W-1:0]   eprod_s1;
	logic [ccr_pkg::MASS_W-1:0]    mb_s1;
	logic [ccr_pkg::MSUM_W-1:0]    msum_s1;
	logic [ccr_pkg::D2_W-1:0]      d2;
	ccr_pkg::item_t                item_ovl;

	// take magnitudes, radius sum, clamped bounce factors and mass sum
	always_comb begin
		ox_u = offset_x;
		oy_u = offset_y;
		ox_mag = ox_u[ccr_pkg::MAG_W-1] ? ccr_pkg::MAG_W'(~ox_u + 1'b1) : ox_u;
		oy_mag = oy_u[ccr_pkg::MAG_W-1] ? ccr_pkg::MAG_W'(~oy_u + 1'b1) : oy_u;
		rs = ccr_pkg::MAG_W'(a_radius) + ccr_pkg::MAG_W'(b_radius);
		ea_sat = (a_bounce > ccr_pkg::BNC_W'(ccr_pkg::BOUNCE_ONE)) ?
			ccr_pkg::BNC_W'(ccr_pkg::BOUNCE_ONE) : a_bounce;
		eb_sat = (b_bounce > ccr_pkg::BNC_W'(ccr_pkg::BOUNCE_ONE)) ?
			ccr_pkg::BNC_W'(ccr_pkg::BOUNCE_ONE) : b_bounce;
		msum = ccr_pkg::MSUM_W'(a_mass) + ccr_pkg::MSUM_W'(b_mass);
	end

	assign d2 = ox2_s1 + oy2_s1;

	// fill in the overlap flag and the combined bounce factor
	always_comb begin
		item_ovl = item_s1;
		item_ovl.ovl = (d2 < rs2_s1);
		item_ovl.e = ccr_pkg::E_W'(eprod_s1 >> ccr_pkg::BNC_FRAC);
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	// stage one: squares and products; stage two: distance sum and overlap test
	always_ff @(posedge clk) begin
		ox2_s1 <= ox_mag * ox_mag;
		oy2_s1 <= oy_mag * oy_mag;
		rs2_s1 <= rs * rs;
		eprod_s1 <= ea_sat * eb_sat;
		mb_s1 <= b_mass;
		msum_s1 <= msum;
		item_s1.ovl <= 1'b0;
		item_s1.e <= '0;
		item_s1.dvx <= ccr_pkg::DV_W'(a_vel_x) - ccr_pkg::DV_W'(b_vel_x);
		item_s1.dvy <= ccr_pkg::DV_W'(a_vel_y) - ccr_pkg::DV_W'(b_vel_y);
		item_s1.avx <= a_vel_x;
		item_s1.avy <= a_vel_y;
		item_s1.bvx <= b_vel_x;
		item_s1.bvy <= b_vel_y;
		item_s1.ox_neg <= offset_x[ccr_pkg::OFS_W-1];
		item_s1.oy_neg <= offset_y[ccr_pkg::OFS_W-1];
		item_s1.ox_mag <= ox_mag;
		item_s1.oy_mag <= oy_mag;
		item_s1.msum_zero <= (msum == '0);

		item_s2 <= item_ovl;
		d2_s2 <= d2;
		mb_s2 <= mb_s1;
		msum_s2 <= msum_s1;
	end

endmodule

>>> rtl/core/ccr_root.sv
// Pipelined integer square root of the squared distance, with the mass weight divider alongside.
module ccr_root (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vld_in,
	input  ccr_pkg::item_t                    item_in,
	input  logic [ccr_pkg::D2_W-1:0]          d2_in,
	input  logic [ccr_pkg::MASS_W-1:0]        mb_in,
	input  logic [ccr_pkg::MSUM_W-1:0]        msum_in,
	output logic                              vld_out,
	output ccr_pkg::item_t                    item_out,
	output logic [ccr_pkg::LEN_W-1:0]         len_out,
	output logic [ccr_pkg::WQ_W-1:0]          wq_out,
	output logic                              wr_nz_out
);

	localparam int N = ccr_pkg::ROOT_STAGES;

	logic                             vld_s   [N];
	ccr_pkg::item_t                   item_s  [N];
	logic [ccr_pkg::D2_W-1:0]         d2_s    [N];
	logic [ccr_pkg::REM_W-1:0]        rem_s   [N];
	logic [ccr_pkg::LEN_W-1:0]        root_s  [N];
	logic [ccr_pkg::MSUM_W-1:0]       wr_s    [N];
	logic [ccr_pkg::MSUM_W-1:0]       msum_s  [N];
	logic [ccr_pkg::WQ_W-1:0]         wq_s    [N];
	logic [ccr_pkg::MBL_W-1:0]        mbl_s   [N];

	genvar k;
	for (k = 0; k < N; k++) begin : g_stage
		logic                          vld_p;
		ccr_pkg::item_t                item_p;
		logic [ccr_pkg::D2_W-1:0]      d2_p;
		logic [ccr_pkg::REM_W-1:0]     rem_p;
		logic [ccr_pkg::LEN_W-1:0]     root_p;
		logic [ccr_pkg::MSUM_W-1:0]    wr_p;
		logic [ccr_pkg::MSUM_W-1:0]    msum_p;
		logic [ccr_pkg::WQ_W-1:0]      wq_p;
		logic [ccr_pkg::MBL_W-1:0]     mbl_p;
		logic [ccr_pkg::REM_W+1:0]     sh;
		logic [ccr_pkg::LEN_W+1:0]     tr;
		logic                          take;
		logic [ccr_pkg::MSUM_W:0]      wsh;
		logic                          wtake;

		if (k == 0) begin : g_first
			assign vld_p = vld_in;
			assign item_p = item_in;
			assign d2_p = d2_in;
			assign rem_p = '0;
			assign root_p = '0;
			assign wr_p = ccr_pkg::MSUM_W'(mb_in >> ccr_pkg::MBL_W);
			assign msum_p = msum_in;
			assign wq_p = '0;
			assign mbl_p = mb_in[ccr_pkg::MBL_W-1:0];
		end else begin : g_next
			assign vld_p = vld_s[k-1];
			assign item_p = item_s[k-1];
			assign d2_p = d2_s[k-1];
			assign rem_p = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign wr_p = wr_s[k-1];
			assign msum_p = msum_s[k-1];
			assign wq_p = wq_s[k-1];
			assign mbl_p = mbl_s[k-1];
		end

		// root digit: bring down two bits and try 4q+1
		assign sh = {rem_p, d2_p[ccr_pkg::D2_W-1 -: 2]};
		assign tr = {root_p, 2'b01};
		assign take = (sh >= (ccr_pkg::REM_W+2)'(tr));

		// weight digit: bring down one numerator bit and try the mass sum
		assign wsh = {wr_p, mbl_p[ccr_pkg::MBL_W-1]};
		assign wtake = (wsh >= (ccr_pkg::MSUM_W+1)'(msum_p));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			item_s[k] <= item_p;
			d2_s[k] <= {d2_p[ccr_pkg::D2_W-3:0], 2'b00};
			rem_s[k] <= take ? ccr_pkg::REM_W'(sh - (ccr_pkg::REM_W+2)'(tr)) :
				sh[ccr_pkg::REM_W-1:0];
			root_s[k] <= {root_p[ccr_pkg::LEN_W-2:0], take};
			wr_s[k] <= wtake ? ccr_pkg::MSUM_W'(wsh - (ccr_pkg::MSUM_W+1)'(msum_p)) :
				wsh[ccr_pkg::MSUM_W-1:0];
			msum_s[k] <= msum_p;
			wq_s[k] <= {wq_p[ccr_pkg::WQ_W-2:0], wtake};
			mbl_s[k] <= ccr_pkg::MBL_W'({mbl_p, 1'b0});
		end
	end

	assign vld_out = vld_s[N-1];
	assign item_out = item_s[N-1];
	assign len_out = root_s[N-1];
	assign wq_out = wq_s[N-1];
	assign wr_nz_out = (wr_s[N-1] != '0);

endmodule

>>> rtl/core/ccr_norm.sv
// Pipelined two-lane divider that scales the centre offset to a unit normal.
module ccr_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vld_in,
	input  ccr_pkg::item_t                    item_in,
	input  logic [ccr_pkg::LEN_W-1:0]         len_in,
	input  logic [ccr_pkg::WQ_W-1:0]          wq_in,
	input  logic                              wr_nz_in,
	output logic                              vld_out,
	output ccr_pkg::item_t                    item_out,
	output logic [ccr_pkg::NMAG_W-1:0]        nx_mag,
	output logic [ccr_pkg::NMAG_W-1:0]        ny_mag,
	output logic [ccr_pkg::W_W-1:0]           wa_out,
	output logic [ccr_pkg::W_W-1:0]           wb_out
);

	localparam int N = ccr_pkg::NORM_BITS;

	logic                          vld_s  [N];
	ccr_pkg::item_t                item_s [N];
	logic [ccr_pkg::LEN_W-1:0]     len_s  [N];
	logic [ccr_pkg::LEN_W-1:0]     rx_s   [N];
	logic [ccr_pkg::LEN_W-1:0]     ry_s   [N];
	logic [ccr_pkg::NMAG_W-1:0]    qx_s   [N];
	logic [ccr_pkg::NMAG_W-1:0]    qy_s   [N];
	logic [ccr_pkg::W_W-1:0]       wa_s   [N];
	logic [ccr_pkg::W_W-1:0]       wb_s   [N];

	logic [ccr_pkg::W_W-1:0]       wb_in, wa_in;

	// finish the weights: B from the quotient, A as its complement less one on a remainder
	always_comb begin
		wb_in = item_in.msum_zero ? '0 : wq_in[ccr_pkg::W_W-1:0];
		wa_in = item_in.msum_zero ? '0 :
			ccr_pkg::W_W'((ccr_pkg::W_W)'(1 << ccr_pkg::W_BITS) - wb_in - ccr_pkg::W_W'(wr_nz_in));
	end

	genvar k;
	for (k = 0; k < N; k++) begin : g_stage
		logic                          vld_p;
		ccr_pkg::item_t                item_p;
		logic [ccr_pkg::LEN_W-1:0]     len_p, rx_p, ry_p;
		logic [ccr_pkg::NMAG_W-1:0]    qx_p, qy_p;
		logic [ccr_pkg::W_W-1:0]       wa_p, wb_p;
		logic                          bx, by;
		logic [ccr_pkg::LEN_W:0]       shx, shy;
		logic                          tx, ty;

		if (k == 0) begin : g_first
			assign vld_p = vld_in;
			assign item_p = item_in;
			assign len_p = len_in;
			assign rx_p = ccr_pkg::LEN_W'(item_in.ox_mag >> 1);
			assign ry_p = ccr_pkg::LEN_W'(item_in.oy_mag >> 1);
			assign qx_p = '0;
			assign qy_p = '0;
			assign wa_p = wa_in;
			assign wb_p = wb_in;
			assign bx = item_in.ox_mag[0];
			assign by = item_in.oy_mag[0];
		end else begin : g_next
			assign vld_p = vld_s[k-1];
			assign item_p = item_s[k-1];
			assign len_p = len_s[k-1];
			assign rx_p = rx_s[k-1];
			assign ry_p = ry_s[k-1];
			assign qx_p = qx_s[k-1];
			assign qy_p = qy_s[k-1];
			assign wa_p = wa_s[k-1];
			assign wb_p = wb_s[k-1];
			assign bx = 1'b0;
			assign by = 1'b0;
		end

		// one quotient bit a stage in each lane
		assign shx = {rx_p, bx};
		assign shy = {ry_p, by};
		assign tx = (shx >= (ccr_pkg::LEN_W+1)'(len_p));
		assign ty = (shy >= (ccr_pkg::LEN_W+1)'(len_p));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			item_s[k] <= item_p;
			len_s[k] <= len_p;
			rx_s[k] <= tx ? ccr_pkg::LEN_W'(shx - (ccr_pkg::LEN_W+1)'(len_p)) :
				shx[ccr_pkg::LEN_W-1:0];
			ry_s[k] <= ty ? ccr_pkg::LEN_W'(shy - (ccr_pkg::LEN_W+1)'(len_p)) :
				shy[ccr_pkg::LEN_W-1:0];
			qx_s[k] <= ccr_pkg::NMAG_W'({qx_p, tx});
			qy_s[k] <= ccr_pkg::NMAG_W'({qy_p, ty});
			wa_s[k] <= wa_p;
			wb_s[k] <= wb_p;
		end
	end

	// a zero length gives a zero normal
	assign vld_out = vld_s[N-1];
	assign item_out = item_s[N-1];
	assign nx_mag = (len_s[N-1] == '0) ? '0 : qx_s[N-1];
	assign ny_mag = (len_s[N-1] == '0) ? '0 : qy_s[N-1];
	assign wa_out = wa_s[N-1];
	assign wb_out = wb_s[N-1];

endmodule

>>> rtl/core/ccr_resp.sv
// Response back end: normal dot product, impulse scaling, velocity update and saturation.
module ccr_resp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vld_in,
	input  ccr_pkg::item_t                    item_in,
	input  logic [ccr_pkg::NMAG_W-1:0]        nx_mag,
	input  logic [ccr_pkg::NMAG_W-1:0]        ny_mag,
	input  logic [ccr_pkg::W_W-1:0]           wa_in,
	input  logic [ccr_pkg::W_W-1:0]           wb_in,
	output logic                              vld_s6,
	output logic                              ovl_s6,
	output logic                              resp_s6,
	output logic signed [ccr_pkg::VEL_W-1:0]  avx_s6,
	output logic signed [ccr_pkg::VEL_W-1:0]  avy_s6,
	output logic signed [ccr_pkg::VEL_W-1:0]  bvx_s6,
	output logic signed [ccr_pkg::VEL_W-1:0]  bvy_s6
);

	localparam logic signed [ccr_pkg::SUM_W-1:0] VMAX =
		{{(ccr_pkg::SUM_W-ccr_pkg::VEL_W+1){1'b0}}, {(ccr_pkg::VEL_W-1){1'b1}}};
	localparam logic signed [ccr_pkg::SUM_W-1:0] VMIN =
		{{(ccr_pkg::SUM_W-ccr_pkg::VEL_W+1){1'b1}}, {(ccr_pkg::VEL_W-1){1'b0}}};

	function automatic logic signed [ccr_pkg::VEL_W-1:0] sat_vel(
		input logic signed [ccr_pkg::SUM_W-1:0] v);
		logic signed [ccr_pkg::VEL_W-1:0] r;
		if (v > VMAX) begin
			r = {1'b0, {(ccr_pkg::VEL_W-1){1'b1}}};
		end else if (v < VMIN) begin
			r = {1'b1, {(ccr_pkg::VEL_W-1){1'b0}}};
		end else begin
			r = v[ccr_pkg::VEL_W-1:0];
		end
		return r;
	endfunction

	logic                                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	ccr_pkg::item_t                      item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [ccr_pkg::NMAG_W-1:0]          nxm_s1, nym_s1, nxm_s2, nym_s2;
	logic [ccr_pkg::NMAG_W-1:0]          nxm_s3, nym_s3, nxm_s4, nym_s4;
	logic [ccr_pkg::W_W-1:0]             wa_s1, wb_s1, wa_s2, wb_s2;
	logic signed [ccr_pkg::PX_W-1:0]     px_s1, py_s1;
	logic                                resp_s2, resp_s3, resp_s4, resp_s5;
	logic                                dneg_s2, dneg_s3, dneg_s4, dneg_s5;
	logic [ccr_pkg::DVM_W-1:0]           dv_s2;
	logic [ccr_pkg::T_W-1:0]             ta_s3, tb_s3;
	logic [ccr_pkg::Q_W-1:0]             qa_s4, qb_s4;
	logic [ccr_pkg::D_W-1:0]             dax_s5, day_s5, dbx_s5, dby_s5;

	logic signed [ccr_pkg::NS_W-1:0]     nxs, nys;
	logic signed [ccr_pkg::PX_W-1:0]     px, py;
	logic signed [ccr_pkg::DOT_W-1:0]    dot;
	logic [ccr_pkg::DOT_W-1:0]           dmag;
	logic [ccr_pkg::DVM_W+ccr_pkg::W_W-1:0] pa, pb;
	logic [ccr_pkg::T_W+ccr_pkg::E_W-1:0]   ea, eb;
	logic [ccr_pkg::Q_W+ccr_pkg::NMAG_W-1:0] pax, pay, pbx, pby;
	logic signed [ccr_pkg::SUM_W-1:0]    sax, say, sbx, sby;
	logic signed [ccr_pkg::SUM_W-1:0]    nax, nay, nbx, nby;

	// signed normal and its products with the relative velocity
	always_comb begin
		nxs = $signed({1'b0, nx_mag});
		nys = $signed({1'b0, ny_mag});
		if (item_in.ox_neg) begin
			nxs = -nxs;
		end
		if (item_in.oy_neg) begin
			nys = -nys;
		end
	end
	assign px = $signed(item_in.dvx) * nxs;
	assign py = $signed(item_in.dvy) * nys;

	// dot product, its sign and scaled magnitude
	always_comb begin
		dot = ccr_pkg::DOT_W'(px_s1) + ccr_pkg::DOT_W'(py_s1);
		dmag = dot[ccr_pkg::DOT_W-1] ? ccr_pkg::DOT_W'(-dot) : ccr_pkg::DOT_W'(dot);
	end

	// impulse products
	assign pa = dv_s2 * wb_s2;
	assign pb = dv_s2 * wa_s2;
	assign ea = ta_s3 * item_s3.e;
	assign eb = tb_s3 * item_s3.e;
	assign pax = qa_s4 * nxm_s4;
	assign pay = qa_s4 * nym_s4;
	assign pbx = qb_s4 * nxm_s4;
	assign pby = qb_s4 * nym_s4;

	// signed velocity changes and updated velocities
	always_comb begin
		sax = ccr_pkg::SUM_W'($signed({1'b0, dax_s5}));
		say = ccr_pkg::SUM_W'($signed({1'b0, day_s5}));
		sbx = ccr_pkg::SUM_W'($signed({1'b0, dbx_s5}));
		sby = ccr_pkg::SUM_W'($signed({1'b0, dby_s5}));
		if (dneg_s5 ^ item_s5.ox_neg) begin
			sax = -sax;
			sbx = -sbx;
		end
		if (dneg_s5 ^ item_s5.oy_neg) begin
			say = -say;
			sby = -sby;
		end
		nax = ccr_pkg::SUM_W'($signed(item_s5.avx)) - sax;
		nay = ccr_pkg::SUM_W'($signed(item_s5.avy)) - say;
		nbx = ccr_pkg::SUM_W'($signed(item_s5.bvx)) + sbx;
		nby = ccr_pkg::SUM_W'($signed(item_s5.bvy)) + sby;
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		item_s1 <= item_in;
		nxm_s1 <= nx_mag;
		nym_s1 <= ny_mag;
		wa_s1 <= wa_in;
		wb_s1 <= wb_in;
		px_s1 <= px;
		py_s1 <= py;

		item_s2 <= item_s1;
		nxm_s2 <= nxm_s1;
		nym_s2 <= nym_s1;
		wa_s2 <= wa_s1;
		wb_s2 <= wb_s1;
		resp_s2 <= item_s1.ovl && (dot <= 0);
		dneg_s2 <= dot[ccr_pkg::DOT_W-1];
		dv_s2 <= dmag[ccr_pkg::DOT_W-1:ccr_pkg::FRAC_BITS];

		item_s3 <= item_s2;
		nxm_s3 <= nxm_s2;
		nym_s3 <= nym_s2;
		resp_s3 <= resp_s2;
		dneg_s3 <= dneg_s2;
		ta_s3 <= pa[ccr_pkg::DVM_W+ccr_pkg::W_W-1:ccr_pkg::W_BITS];
		tb_s3 <= pb[ccr_pkg::DVM_W+ccr_pkg::W_W-1:ccr_pkg::W_BITS];

		item_s4 <= item_s3;
		nxm_s4 <= nxm_s3;
		nym_s4 <= nym_s3;
		resp_s4 <= resp_s3;
		dneg_s4 <= dneg_s3;
		qa_s4 <= {ea[ccr_pkg::T_W+ccr_pkg::E_W-1:ccr_pkg::BNC_FRAC], 1'b0};
		qb_s4 <= {eb[ccr_pkg::T_W+ccr_pkg::E_W-1:ccr_pkg::BNC_FRAC], 1'b0};

		item_s5 <= item_s4;
		resp_s5 <= resp_s4;
		dneg_s5 <= dneg_s4;
		dax_s5 <= pax[ccr_pkg::Q_W+ccr_pkg::NMAG_W-1:ccr_pkg::FRAC_BITS];
		day_s5 <= pay[ccr_pkg::Q_W+ccr_pkg::NMAG_W-1:ccr_pkg::FRAC_BITS];
		dbx_s5 <= pbx[ccr_pkg::Q_W+ccr_pkg::NMAG_W-1:ccr_pkg::FRAC_BITS];
		dby_s5 <= pby[ccr_pkg::Q_W+ccr_pkg::NMAG_W-1:ccr_pkg::FRAC_BITS];

		// pass the input velocities through unless the pair responds
		ovl_s6 <= item_s5.ovl;
		resp_s6 <= resp_s5;
		avx_s6 <= resp_s5 ? sat_vel(nax) : item_s5.avx;
		avy_s6 <= resp_s5 ? sat_vel(nay) : item_s5.avy;
		bvx_s6 <= resp_s5 ? sat_vel(nbx) : item_s5.bvx;
		bvy_s6 <= resp_s5 ? sat_vel(nby) : item_s5.bvy;
	end

endmodule

>>> dv/ccr_checker.sv
// Checker for the circle collision response block: predicts each pair and compares results.
module ccr_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic signed [ccr_pkg::OFS_W-1:0]     offset_x,
	input  logic signed [ccr_pkg::OFS_W-1:0]     offset_y,
	input  logic signed [ccr_pkg::VEL_W-1:0]     a_vel_x,
	input  logic signed [ccr_pkg::VEL_W-1:0]     a_vel_y,
	input  logic signed [ccr_pkg::VEL_W-1:0]     b_vel_x,
	input  logic signed [ccr_pkg::VEL_W-1:0]     b_vel_y,
	input  logic [ccr_pkg::MASS_W-1:0]           a_mass,
	input  logic [ccr_pkg::MASS_W-1:0]           b_mass,
	input  logic [ccr_pkg::RAD_W-1:0]            a_radius,
	input  logic [ccr_pkg::RAD_W-1:0]            b_radius,
	input  logic [ccr_pkg::BNC_W-1:0]            a_bounce,
	input  logic [ccr_pkg::BNC_W-1:0]            b_bounce,
	input  logic                                 done,
	input  logic                                 overlapping,
	input  logic                                 responded,
	input  logic signed [ccr_pkg::VEL_W-1:0]     new_a_vel_x,
	input  logic signed [ccr_pkg::VEL_W-1:0]     new_a_vel_y,
	input  logic signed [ccr_pkg::VEL_W-1:0]     new_b_vel_x,
	input  logic signed [ccr_pkg::VEL_W-1:0]     new_b_vel_y,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   hit_count,
	output int                                   resp_count
);

	typedef struct {
		bit                              ovl;
		bit                              resp;
		bit signed [ccr_pkg::VEL_W-1:0]  avx;
		bit signed [ccr_pkg::VEL_W-1:0]  avy;
		bit signed [ccr_pkg::VEL_W-1:0]  bvx;
		bit signed [ccr_pkg::VEL_W-1:0]  bvy;
	} response_t;

	response_t response_q[$];

	function automatic bit [63:0] abs64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic bit [63:0] int_root(bit [63:0] d);
		bit [63:0] r;
		bit [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > d)
			b >>= 2;
		while (b != 0) begin
			if (d >= r + b) begin
				d -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint normal_comp(longint c, bit [63:0] len);
		bit [63:0] q;
		if (len == 0)
			return 0;
		q = (abs64(c) << ccr_pkg::FRAC_BITS) / len;
		return c < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic bit [63:0] impulse_mag(bit [63:0] dv, bit [63:0] w, bit [63:0] e);
		bit [63:0] t;
		t = (dv * w) >> ccr_pkg::W_BITS;
		return ((t * e) >> ccr_pkg::BNC_FRAC) * 2;
	endfunction

	function automatic longint push_vel(longint v, longint nc, bit [63:0] q, bit dneg,
			bit sub);
		longint d;
		d = longint'((q * abs64(nc)) >> ccr_pkg::FRAC_BITS);
		if (dneg != (nc < 0))
			d = -d;
		return clamp32(sub ? v - d : v + d);
	endfunction

	// predict the response of one circle pair
	function automatic response_t predict_response();
		response_t r;
		longint ox, oy, avx, avy, bvx, bvy, nx, ny, dot;
		bit [63:0] d2, rs, len, ma, mb, msum, wa, wb, ea, eb, e, dv, qa, qb;
		bit dneg;
		ox = longint'(offset_x);
		oy = longint'(offset_y);
		avx = longint'(a_vel_x);
		avy = longint'(a_vel_y);
		bvx = longint'(b_vel_x);
		bvy = longint'(b_vel_y);
		ma = a_mass;
		mb = b_mass;
		ea = a_bounce;
		eb = b_bounce;
		r.avx = a_vel_x;
		r.avy = a_vel_y;
		r.bvx = b_vel_x;
		r.bvy = b_vel_y;
		r.resp = 0;
		d2 = abs64(ox) * abs64(ox) + abs64(oy) * abs64(oy);
		rs = 64'(a_radius) + 64'(b_radius);
		r.ovl = d2 < rs * rs;
		if (r.ovl) begin
			len = int_root(d2);
			nx = normal_comp(ox, len);
			ny = normal_comp(oy, len);
			dot = (avx - bvx) * nx + (avy - bvy) * ny;
			if (dot <= 0) begin
				r.resp = 1;
				if (ea > ccr_pkg::BOUNCE_ONE)
					ea = ccr_pkg::BOUNCE_ONE;
				if (eb > ccr_pkg::BOUNCE_ONE)
					eb = ccr_pkg::BOUNCE_ONE;
				e = (ea * eb) >> ccr_pkg::BNC_FRAC;
				msum = ma + mb;
				wa = 0;
				wb = 0;
				if (msum != 0) begin
					wb = (mb << ccr_pkg::W_BITS) / msum;
					wa = (ma << ccr_pkg::W_BITS) / msum;
				end
				dneg = dot < 0;
				dv = abs64(dot) >> ccr_pkg::FRAC_BITS;
				qa = impulse_mag(dv, wb, e);
				qb = impulse_mag(dv, wa, e);
				r.avx = 32'(push_vel(avx, nx, qa, dneg, 1));
				r.avy = 32'(push_vel(avy, ny, qa, dneg, 1));
				r.bvx = 32'(push_vel(bvx, nx, qb, dneg, 0));
				r.bvy = 32'(push_vel(bvy, ny, qb, dneg, 0));
			end
		end
		return r;
	endfunction

	// queue a prediction per start beat, compare each strobed result
	always @(posedge clk or negedge arst_n) begin
		response_t exp_r;
		if (!arst_n) begin
			fail_count <= 0;
			hit_count <= 0;
			resp_count <= 0;
			response_q.delete();
			pending <= 0;
		end else begin
			if (start && !busy)
				response_q.push_back(predict_response());
			if (done) begin
				if (response_q.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected result beat");
					fail_count <= fail_count + 1;
				end else begin
					exp_r = response_q.pop_front();
					hit_count <= hit_count + exp_r.ovl;
					resp_count <= resp_count + exp_r.resp;
					if (overlapping !== exp_r.ovl || responded !== exp_r.resp ||
							new_a_vel_x !== exp_r.avx || new_a_vel_y !== exp_r.avy ||
							new_b_vel_x !== exp_r.bvx || new_b_vel_y !== exp_r.bvy) begin
						if (fail_count < 10)
							$display("ERROR: exp ovl %0b resp %0b a %0d,%0d b %0d,%0d; got ovl %0b resp %0b a %0d,%0d b %0d,%0d",
								exp_r.ovl, exp_r.resp, exp_r.avx, exp_r.avy, exp_r.bvx,
								exp_r.bvy, overlapping, responded, new_a_vel_x,
								new_a_vel_y, new_b_vel_x, new_b_vel_y);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= response_q.size();
		end
	end

endmodule

>>> dv/tb_top.sv
// Testbench top for the circle collision response block: stimulus and verdict.
module tb_top;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done, overlapping, responded;
	logic signed [ccr_pkg::OFS_W-1:0] offset_x = 0, offset_y = 0;
	logic signed [ccr_pkg::VEL_W-1:0] a_vel_x = 0, a_vel_y = 0, b_vel_x = 0, b_vel_y = 0;
	logic [ccr_pkg::MASS_W-1:0] a_mass = 1, b_mass = 1;
	logic [ccr_pkg::RAD_W-1:0] a_radius = 0, b_radius = 0;
	logic [ccr_pkg::BNC_W-1:0] a_bounce = 0, b_bounce = 0;
	logic signed [ccr_pkg::VEL_W-1:0] new_a_vel_x, new_a_vel_y, new_b_vel_x, new_b_vel_y;
	int fail_count, pending, hit_count, resp_count;
	int gap_pct;
	int beat_count;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	circle_collision_response dut (.*);
	ccr_checker checker_i (.*);

	// load one pair onto the ports
	task automatic set_pair(int ox, int oy, int avx, int avy, int bvx, int bvy,
			int unsigned ma, int unsigned mb, int unsigned ra, int unsigned rb,
			int unsigned ea, int unsigned eb);
		offset_x <= ox;
		offset_y <= oy;
		a_vel_x <= avx;
		a_vel_y <= avy;
		b_vel_x <= bvx;
		b_vel_y <= bvy;
		a_mass <= ma;
		b_mass <= mb;
		a_radius <= ccr_pkg::RAD_W'(ra);
		b_radius <= ccr_pkg::RAD_W'(rb);
		a_bounce <= ccr_pkg::BNC_W'(ea);
		b_bounce <= ccr_pkg::BNC_W'(eb);
	endtask

	// present the loaded pair for one beat, with a random leading gap
	task automatic send_beat();
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		beat_count++;
		@(negedge clk);
	endtask

	function automatic int rnd_field();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
			default: return int'($urandom_range(2000000)) - 1000000;
		endcase
	endfunction

	// random pair, mostly close enough to collide
	task automatic random_pair();
		int ox, oy;
		int unsigned ra, rb;
		ox = $urandom_range(3) == 0 ? rnd_field() : int'($urandom_range(400000)) - 200000;
		oy = $urandom_range(3) == 0 ? rnd_field() : int'($urandom_range(400000)) - 200000;
		if ($urandom_range(9) == 0) begin
			ox = 0;
			oy = 0;
		end
		ra = $urandom_range(3) == 0 ? ($urandom >> 1) : $urandom_range(200000);
		rb = $urandom_range(3) == 0 ? ($urandom >> 1) : $urandom_range(200000);
		set_pair(ox, oy, rnd_field(), rnd_field(), rnd_field(), rnd_field(),
			$urandom_range(3) == 0 ? $urandom | 1 : $urandom_range(1, 1 << 20),
			$urandom_range(3) == 0 ? $urandom | 1 : $urandom_range(1, 1 << 20),
			ra, rb, $urandom_range(131071), $urandom_range(ccr_pkg::BOUNCE_ONE));
	endtask

	initial begin
		#100000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		gap_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: head-on, zero offset, separating, no overlap, extremes
		set_pair(32'h10000, 0, -32'h10000, 0, 32'h10000, 0, 32'h10000, 32'h10000,
			32'h10000, 32'h10000, ccr_pkg::BOUNCE_ONE, ccr_pkg::BOUNCE_ONE);
		send_beat();
		set_pair(0, 0, 5, 6, 7, 8, 1, 1, 1, 0, ccr_pkg::BOUNCE_ONE, ccr_pkg::BOUNCE_ONE);
		send_beat();
		set_pair(0, 0, 5, 6, 7, 8, 1, 1, 0, 0, 0, 0);
		send_beat();
		set_pair(32'h10000, 0, 32'h10000, 0, -32'h10000, 0, 1, 1, 32'h10000, 32'h10000,
			ccr_pkg::BOUNCE_ONE, ccr_pkg::BOUNCE_ONE);
		send_beat();
		set_pair(32'h7fffffff, 32'h7fffffff, 1, 2, 3, 4, 1, 1, 1, 1, 0, 0);
		send_beat();
		set_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'hffffffff, 32'hffffffff,
			32'h7fffffff, 32'h7fffffff, 131071, 131071);
		send_beat();
		set_pair(32'h80000000, 0, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 1, 32'hffffffff, 32'h7fffffff, 32'h7fffffff, 131071, 131071);
		send_beat();
		set_pair(-3, 4, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'hffffffff, 1, 10, 10, ccr_pkg::BOUNCE_ONE, 32768);
		send_beat();
		set_pair(100, -100, 0, 0, 0, 0, 1, 1, 100, 41, 65535, 1);
		send_beat();
		set_pair(-1, -1, -1, -1, -1, -1, 32'hffffffff, 32'hffffffff, 32'h7fffffff, 0,
			ccr_pkg::BOUNCE_ONE, ccr_pkg::BOUNCE_ONE);
		send_beat();

		// random phases: light sender gaps, heavy gaps, back to back
		gap_pct = 8;
		repeat (620) begin
			random_pair();
			send_beat();
		end
		start <= 0;
		while (pending != 0)
			@(negedge clk);
		gap_pct = 77;
		repeat (600) begin
			random_pair();
			send_beat();
		end
		gap_pct = 0;
		repeat (620) begin
			random_pair();
			send_beat();
		end
		start <= 0;

		// drain
		while (pending != 0)
			@(negedge clk);
		repeat (ccr_pkg::LATENCY + 10) @(negedge clk);
		$display("Sent %0d circle pairs: %0d overlapping, %0d with a response applied.",
			beat_count, hit_count, resp_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ccr_pkg.sv
rtl/core/ccr_prep.sv
rtl/core/ccr_root.sv
rtl/core/ccr_norm.sv
rtl/core/ccr_resp.sv
rtl/core/circle_collision_response.sv
dv/ccr_checker.sv
dv/tb_top.sv
